// ----- sv/otp_fuse_controller_top_macros.svh -----
// ----------------------------------------------------------------------------
// OTP fuse controller assertion macros
// Concurrent assertion wrappers, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OTP_FUSE_CONTROLLER_TOP_MACROS_SVH
`define OTP_FUSE_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define OFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define OFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OFC_ASSERT_IMP(label, ante, cons, msg)
`define OFC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/ofc_pkg.sv -----
// ----------------------------------------------------------------------------
// OTP fuse controller package
// Constants, types and range-map functions of the fuse controller.
// ----------------------------------------------------------------------------
package ofc_pkg;

  localparam int unsigned FUSE_WORDS = 128;
  localparam int unsigned WORD_AW    = $clog2(FUSE_WORDS);
  localparam int unsigned BIT_AW     = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned DELAY_W    = 10;
  localparam int unsigned VARIANT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [DATA_W-1:0] MAGIC_PROGRAM = 32'h6675_7365;
  localparam logic [DATA_W-1:0] MAGIC_OUT_EN  = 32'h656E_626C;
  localparam logic [DATA_W-1:0] MAGIC_SUPPLY  = 32'h0564_4451;

  localparam logic [DELAY_W-1:0]   DELAY_RESET   = 10'd250;
  localparam logic [VARIANT_W-1:0] VARIANT_OLD   = 2'd0;
  localparam logic [VARIANT_W-1:0] VARIANT_NEW   = 2'd2;
  localparam logic [VARIANT_W-1:0] VARIANT_BAD   = 2'd3;

  // Bus map.
  localparam logic [ADDR_W-1:0] FUSE_WIN_END = 15'h200;
  localparam logic [ADDR_W-1:0] REG_CTRL     = 15'h200;
  localparam logic [ADDR_W-1:0] REG_PBA      = 15'h204;
  localparam logic [ADDR_W-1:0] REG_PROG     = 15'h208;
  localparam logic [ADDR_W-1:0] REG_OUT_EN   = 15'h20C;
  localparam logic [ADDR_W-1:0] REG_SUPPLY   = 15'h210;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 1'b1;

  // Every read-once and last-time-program fuse sits in word 29; the global
  // lock (fuse 994) is bit 2 of word 31.
  localparam logic [WORD_AW-1:0] LOCK_WORD       = 7'd29;
  localparam logic [WORD_AW-1:0] GLOBAL_WORD     = 7'd31;
  localparam logic [4:0]         GLOBAL_LOCK_BIT = 5'd2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic supply;
    logic out_en;
    logic busy;
  } ctl_t;

  typedef struct packed {
    logic       covered;
    logic       guarded;
    logic [4:0] bit_sel;  // bit within the lock word
  } guard_t;

  typedef struct packed {
    logic       locked;
    logic [4:0] bit_sel;  // bit within the lock word
  } lock_t;

  // Read-once guard of a fuse word.
  function automatic guard_t word_guard(logic [WORD_AW-1:0] w,
                                        logic [VARIANT_W-1:0] variant);
    guard_t g;
    g = '{covered: 1'b1, guarded: 1'b0, bit_sel: 5'd0};
    if (w < 7'd28) begin
      g.guarded = 1'b1;
      g.bit_sel = w[6:2];
    end else if (w == 7'd28) begin
      g.covered = (variant == VARIANT_NEW);
      g.guarded = (variant == VARIANT_NEW);
      g.bit_sel = 5'd6;
    end else if (w == 7'd30) begin
      g.covered = 1'b0;
    end else if (w != 7'd29 && w != 7'd31) begin
      g.guarded = 1'b1;
      g.bit_sel = 5'd6 + {3'b000, w[6:5]};
    end
    return g;
  endfunction

  // Last-time-program fuse of the range that covers fuse bit b.
  function automatic lock_t bit_lock(logic [BIT_AW-1:0] b, logic [VARIANT_W-1:0] variant);
    lock_t l;
    l = '{locked: 1'b0, bit_sel: 5'd0};
    if (b < 12'd896) begin
      l.locked  = 1'b1;
      l.bit_sel = 5'd10 + {2'b00, b[9:7]};
    end else if (b < 12'd904) begin
      l.locked  = (variant == VARIANT_NEW);
      l.bit_sel = 5'd16;
    end else if (b >= 12'd1024) begin
      l.locked  = 1'b1;
      l.bit_sel = 5'd16 + {3'b000, b[11:10]};
    end
    return l;
  endfunction

endpackage

// ----- sv/otp_fuse_controller_top.sv -----
// ----------------------------------------------------------------------------
// OTP fuse controller
// 4096-fuse one-time-programmable block behind a register window, with
// range-map read protection, program locking and a tick-timed powered blow.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Payload
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tuser: command; tdata: address, write_data
//  m_axis    | out       | tdata: read_data
//  cfg       | in        | index 0 device_variant, index 1 program_delay_ticks
//
// One item is accepted per cycle while the input stage can move. The fuse word is
// read from memory as the item enters, through the registered read port, and its
// result is registered in the output register. A write by the item ahead is
// forwarded into the word just read. Reset is asynchronous and clears the
// per-word valid flags, so the store reads as zero at once with no clearing pass.
// A stalled output holds the input stage; ready drops only while it cannot move.
// ----------------------------------------------------------------------------

`include "otp_fuse_controller_top_macros.svh"

module otp_fuse_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Stream in.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [47:0]                     s_axis_tdata_i,   // [14:0] address,
                                                            // [46:15] write_data
  input  logic [1:0]                      s_axis_tuser_i,   // [1:0] command
  // Stream out.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [31:0]                     m_axis_tdata_o,   // [31:0] read_data
  // Configuration writes.
  input  logic                            cfg_we_i,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ofc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned WAW = ofc_pkg::WORD_AW;
  localparam int unsigned DW  = ofc_pkg::DATA_W;

  // Configuration registers.
  logic [ofc_pkg::VARIANT_W-1:0] variant_q;
  logic [ofc_pkg::DELAY_W-1:0]   ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= ofc_pkg::VARIANT_OLD;
      ticks_q   <= ofc_pkg::DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ofc_pkg::CFG_VARIANT: begin
          // The undefined fourth code falls back to the older map.
          variant_q <= (cfg_wdata_i[1:0] == ofc_pkg::VARIANT_BAD) ?
                       ofc_pkg::VARIANT_OLD : cfg_wdata_i[1:0];
        end
        ofc_pkg::CFG_DELAY: begin
          ticks_q <= cfg_wdata_i;
        end
        default: ;
      endcase
    end
  end

  // Handshake. The input stage processes its item whenever the output
  // register is free or being emptied in the same cycle.
  logic s_valid_q;
  logic m_valid_q;
  logic proc;
  logic in_acc;

  assign proc            = s_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s_valid_q || proc;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Input stage.
  ofc_pkg::cmd_e        cmd_q;
  logic [ofc_pkg::ADDR_W-1:0] addr_q;
  logic [DW-1:0]        wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_acc) begin
      s_valid_q <= 1'b1;
    end else if (proc) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= ofc_pkg::cmd_e'(s_axis_tuser_i);
      addr_q  <= s_axis_tdata_i[14:0];
      wdata_q <= s_axis_tdata_i[46:15];
    end
  end

  // Control state.
  ofc_pkg::ctl_t              ctl_q, ctl_d;
  logic [ofc_pkg::BIT_AW-1:0] pba_q, pba_d;
  logic [ofc_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic [DW-1:0]              m_data_q;

  // Fuse store: a memory with one write and one registered read port. A
  // per-word valid flag stands in for the reset value of the memory, and
  // words 29 and 31 (all lock and guard fuses) are mirrored in flip-flops.
  logic [DW-1:0]         fuse_mem [ofc_pkg::FUSE_WORDS];
  logic [DW-1:0]         rd_q;
  logic [ofc_pkg::FUSE_WORDS-1:0] valid_q;
  logic [DW-1:0]         lock_word_q;
  logic [DW-1:0]         global_word_q;

  logic                  mem_we;
  logic                  mem_full;
  logic [WAW-1:0]        mem_wa;
  logic [DW-1:0]         mem_wd;
  logic [WAW-1:0]        in_word;

  assign in_word = s_axis_tdata_i[WAW+1:2];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (mem_full) begin
        fuse_mem[mem_wa] <= mem_wd;
      end else begin
        fuse_mem[mem_wa][pba_q[4:0]] <= 1'b1;
      end
    end
    if (in_acc) begin
      rd_q <= fuse_mem[in_word];
    end
  end

  // Forwarding of a write made at the same edge as the read of the next item.
  logic          fwd_hit_q;
  logic          fwd_or_q;
  logic [DW-1:0] fwd_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_q <= mem_we && (mem_wa == in_word);
    end else if (proc) begin
      fwd_hit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_or_q   <= !mem_full;
      fwd_word_q <= mem_wd;
    end
  end

  // Word addressed by the item in the input stage.
  logic [WAW-1:0]  s_word;
  logic [DW-1:0]   word_eff;
  ofc_pkg::guard_t guard;
  ofc_pkg::lock_t  lock;
  logic            blocked;
  logic            finish;
  logic            bus_fill;
  logic [DW-1:0]   blow_mask;
  logic [DW-1:0]   rd_val;

  assign s_word = addr_q[WAW+1:2];
  assign guard  = ofc_pkg::word_guard(s_word, variant_q);
  assign lock   = ofc_pkg::bit_lock(pba_q, variant_q);

  // A bit with no range is checked against the global lock alone.
  assign blocked   = global_word_q[ofc_pkg::GLOBAL_LOCK_BIT] ||
                     (lock.locked && lock_word_q[lock.bit_sel]);
  assign blow_mask = DW'(1) << pba_q[4:0];

  always_comb begin
    if (fwd_hit_q) begin
      word_eff = fwd_or_q ? (rd_q | fwd_word_q) : fwd_word_q;
    end else if (valid_q[s_word]) begin
      word_eff = rd_q;
    end else begin
      word_eff = '0;
    end
  end

  always_comb begin
    rd_val   = '0;
    ctl_d    = ctl_q;
    pba_d    = pba_q;
    delay_d  = delay_q;
    finish   = 1'b0;
    bus_fill = 1'b0;

    case (cmd_q)
      ofc_pkg::CMD_READ: begin
        if (addr_q < ofc_pkg::FUSE_WIN_END) begin
          if (!guard.covered) begin
            rd_val = '0;
          end else if (guard.guarded && lock_word_q[guard.bit_sel]) begin
            rd_val = '1;
          end else begin
            rd_val = word_eff;
          end
        end else if (addr_q == ofc_pkg::REG_CTRL) begin
          rd_val = {29'd0, ctl_q};
        end else if (addr_q == ofc_pkg::REG_PBA) begin
          rd_val = {20'd0, pba_q};
        end
      end
      ofc_pkg::CMD_WRITE: begin
        if (addr_q < ofc_pkg::FUSE_WIN_END) begin
          bus_fill = 1'b1;
        end else begin
          unique case (addr_q)
            ofc_pkg::REG_PBA: begin
              pba_d = wdata_q[ofc_pkg::BIT_AW-1:0];
            end
            ofc_pkg::REG_PROG: begin
              if (wdata_q == ofc_pkg::MAGIC_PROGRAM) begin
                if (ctl_q.out_en && ctl_q.supply) begin
                  // Powered blow: wait out the delay; zero counts as one tick.
                  ctl_d.busy = 1'b1;
                  delay_d    = (ticks_q == '0) ? ofc_pkg::DELAY_W'(1) : ticks_q;
                end else begin
                  finish = 1'b1;
                end
              end
            end
            ofc_pkg::REG_OUT_EN: begin
              ctl_d.out_en = (wdata_q == ofc_pkg::MAGIC_OUT_EN);
            end
            ofc_pkg::REG_SUPPLY: begin
              ctl_d.supply = (wdata_q == ofc_pkg::MAGIC_SUPPLY);
            end
            default: ;
          endcase
        end
      end
      ofc_pkg::CMD_TICK: begin
        if (delay_q != '0) begin
          delay_d = delay_q - ofc_pkg::DELAY_W'(1);
          finish  = (delay_q == ofc_pkg::DELAY_W'(1));
        end
      end
      default: ;
    endcase

    if (finish) begin
      ctl_d.busy = 1'b0;
    end
  end

  // Memory write: a full word from the bus, or a single blown fuse. A blow
  // into a word that was never written writes the whole one-hot word.
  always_comb begin
    mem_we   = 1'b0;
    mem_full = 1'b1;
    mem_wa   = s_word;
    mem_wd   = wdata_q;
    if (proc && bus_fill) begin
      mem_we = 1'b1;
    end else if (proc && finish && !blocked) begin
      mem_we   = 1'b1;
      mem_wa   = pba_q[ofc_pkg::BIT_AW-1:5];
      mem_full = !valid_q[pba_q[ofc_pkg::BIT_AW-1:5]];
      mem_wd   = blow_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      lock_word_q   <= '0;
      global_word_q <= '0;
      ctl_q         <= '0;
      pba_q         <= '0;
      delay_q       <= '0;
    end else if (proc) begin
      ctl_q   <= ctl_d;
      pba_q   <= pba_d;
      delay_q <= delay_d;
      if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
        if (mem_wa == ofc_pkg::LOCK_WORD) begin
          lock_word_q <= bus_fill ? wdata_q : (lock_word_q | blow_mask);
        end
        if (mem_wa == ofc_pkg::GLOBAL_WORD) begin
          global_word_q <= bus_fill ? wdata_q : (global_word_q | blow_mask);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (proc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      m_data_q <= rd_val;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Assertions.
  `OFC_ASSERT_IMP(a_busy_has_count, ctl_q.busy, delay_q != '0, "busy without countdown")
  `OFC_ASSERT_NXT(a_stage_holds, s_valid_q && !proc, s_valid_q && $stable(addr_q), "stage lost")
  `OFC_ASSERT_IMP(a_fwd_has_item, fwd_hit_q, s_valid_q, "forward without item")
  `OFC_ASSERT_NXT(a_proc_fills_out, proc, m_valid_q, "result not registered")

endmodule
